FILE: sv/tma_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tma_pkg
// Shared types, register map and arithmetic constants of the trackball
// motion accelerator.
// ----------------------------------------------------------------------------
package tma_pkg;

	localparam int DIV_W = 40;
	localparam int DVS_W = 16;
	localparam int CNT_W = 6;
	localparam int MAG_W = 31;
	localparam int NUM_W = 39;
	localparam int ADDR_W = 5;

	localparam logic [CNT_W-1:0] NB_SHORT = CNT_W'(16);
	localparam logic [CNT_W-1:0] NB_QUAD = CNT_W'(31);
	localparam logic [CNT_W-1:0] NB_BLEND = CNT_W'(39);

	localparam logic [2:0] REG_PTR_SCALE = 3'd0;
	localparam logic [2:0] REG_SCR_SCALE = 3'd1;
	localparam logic [2:0] REG_PTR_WEIGHT = 3'd2;
	localparam logic [2:0] REG_SCR_WEIGHT = 3'd3;
	localparam logic [2:0] REG_CPI = 3'd4;

	localparam logic [7:0] RST_SCALE = 8'd1;
	localparam logic [7:0] RST_WEIGHT = 8'd0;
	localparam logic [15:0] RST_CPI = 16'd800;

	localparam logic [14:0] CAP_MAG = 15'h7fff;

	typedef struct packed {
		logic [7:0]  pointer_scale;
		logic [7:0]  scroll_scale;
		logic [7:0]  pointer_quad_weight;
		logic [7:0]  scroll_quad_weight;
		logic [15:0] sensor_cpi;
	} cfg_t;

	typedef enum logic [12:0] {
		ST_IDLE   = 13'b0000000000001,
		ST_DIV_M  = 13'b0000000000010,
		ST_DIV_DX = 13'b0000000000100,
		ST_DIV_DY = 13'b0000000001000,
		ST_SQ_X   = 13'b0000000010000,
		ST_DIV_QX = 13'b0000000100000,
		ST_SQ_Y   = 13'b0000001000000,
		ST_DIV_QY = 13'b0000010000000,
		ST_MUL_X  = 13'b0000100000000,
		ST_DIV_NX = 13'b0001000000000,
		ST_MUL_Y  = 13'b0010000000000,
		ST_DIV_NY = 13'b0100000000000,
		ST_FIN    = 13'b1000000000000
	} state_t;

	// add a capped component to an accumulator, capping at +-32767
	function automatic logic [15:0] sat_add(input logic [15:0] acc, input logic [16:0] add);
		logic signed [17:0] s;
		s = $signed({{2{acc[15]}}, acc}) + $signed({add[16], add});
		if (s > 18'sd32767)
			return 16'h7fff;
		else if (s < -18'sd32767)
			return 16'h8001;
		else
			return s[15:0];
	endfunction

	// sign-magnitude to 17-bit two's complement, magnitude capped
	function automatic logic [16:0] cap_signed(input logic neg, input logic [MAG_W-1:0] mag);
		logic [14:0] c;
		c = (mag > MAG_W'(CAP_MAG)) ? CAP_MAG : mag[14:0];
		return neg ? (17'd0 - {2'b00, c}) : {2'b00, c};
	endfunction

endpackage

FILE: sv/tma_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tma_div
// Shared restoring divider, one quotient bit per cycle. The dividend comes
// left-aligned; nbits sets the number of iterations.
// ----------------------------------------------------------------------------
module tma_div import tma_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [DIV_W-1:0] dividend,
	input  logic [DVS_W-1:0] divisor,
	input  logic [CNT_W-1:0] nbits,
	output logic             busy,
	output logic             done,
	output logic [DIV_W-1:0] quotient
);

	logic             busy_q;
	logic             done_q;
	logic [CNT_W-1:0] cnt_q;
	logic [DVS_W-1:0] rem_q;
	logic [DVS_W-1:0] dvs_q;
	logic [DIV_W-1:0] quo_q;
	logic [DVS_W:0]   shifted;
	logic [DVS_W:0]   trial;
	logic             fits;

	assign shifted = {rem_q, quo_q[DIV_W-1]};
	assign trial = shifted - {1'b0, dvs_q};
	assign fits = ~trial[DVS_W];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else if (start && !busy_q) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q <= nbits;
		end else if (busy_q) begin
			cnt_q <= cnt_q - 1'b1;
			if (cnt_q == CNT_W'(1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start && !busy_q) begin
			rem_q <= '0;
			quo_q <= dividend;
			dvs_q <= divisor;
		end else if (busy_q) begin
			quo_q <= {quo_q[DIV_W-2:0], fits};
			rem_q <= fits ? trial[DVS_W-1:0] : shifted[DVS_W-1:0];
		end
	end

	assign busy = busy_q;
	assign done = done_q;
	assign quotient = quo_q;

endmodule

FILE: sv/tma_cfg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tma_cfg
// APB register file holding scales, quadratic weights and sensor CPI.
// ----------------------------------------------------------------------------
module tma_cfg import tma_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [31:0]       pwdata,
	output logic [31:0]       prdata,
	output logic              pready,
	output cfg_t              cfg
);

	cfg_t        cfg_q;
	logic        wr_en;
	logic [2:0]  idx;

	assign idx = paddr[4:2];
	assign wr_en = psel && penable && pwrite;
	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.pointer_scale <= RST_SCALE;
			cfg_q.scroll_scale <= RST_SCALE;
			cfg_q.pointer_quad_weight <= RST_WEIGHT;
			cfg_q.scroll_quad_weight <= RST_WEIGHT;
			cfg_q.sensor_cpi <= RST_CPI;
		end else if (wr_en) begin
			unique case (idx)
				REG_PTR_SCALE:  cfg_q.pointer_scale <= pwdata[7:0];
				REG_SCR_SCALE:  cfg_q.scroll_scale <= pwdata[7:0];
				REG_PTR_WEIGHT: cfg_q.pointer_quad_weight <= pwdata[7:0];
				REG_SCR_WEIGHT: cfg_q.scroll_quad_weight <= pwdata[7:0];
				REG_CPI:        cfg_q.sensor_cpi <= pwdata[15:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (idx)
			REG_PTR_SCALE:  prdata = {24'd0, cfg_q.pointer_scale};
			REG_SCR_SCALE:  prdata = {24'd0, cfg_q.scroll_scale};
			REG_PTR_WEIGHT: prdata = {24'd0, cfg_q.pointer_quad_weight};
			REG_SCR_WEIGHT: prdata = {24'd0, cfg_q.scroll_quad_weight};
			REG_CPI:        prdata = {16'd0, cfg_q.sensor_cpi};
			default:        prdata = 32'd0;
		endcase
	end

	assign cfg = cfg_q;

endmodule

FILE: sv/trackball_motion_accelerator.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// trackball_motion_accelerator
// Pointer acceleration curve with saturating pointer and scroll accumulators.
// ----------------------------------------------------------------------------
// A word without motion or in setup mode goes from accept straight to the
// finish state; a motion word first runs seven divisions through the shared
// one-bit-per-cycle divider plus four multiplier steps (the two quadratic
// divisions are skipped when the first quotient is zero). A word is taken
// only in idle, never during a computation, but it is taken while a result waits.
// Reset clears the accumulators and loads register defaults at once.
// ----------------------------------------------------------------------------
module trackball_motion_accelerator import tma_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              s_tvalid,
	output logic              s_tready,
	input  logic [31:0]       s_tdata,   // raw_dx, raw_dy
	input  logic [3:0]        s_tuser,   // motion_valid, scroll_layer, axis_lock, setup_mode
	output logic              m_tvalid,
	input  logic              m_tready,
	output logic [63:0]       m_tdata,   // acc_delta_x, acc_delta_y, acc_scroll_x, acc_scroll_y
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [31:0]       pwdata,
	output logic [31:0]       prdata,
	output logic              pready
);

	cfg_t             cfg;
	state_t           state_q;
	state_t           state_d;

	logic             div_start;
	logic             div_busy;
	logic             div_done;
	logic [DIV_W-1:0] div_quo;
	logic [DIV_W-1:0] div_dividend;
	logic [DVS_W-1:0] div_divisor;
	logic [CNT_W-1:0] div_nbits;
	logic             in_div;
	logic             skip_div;
	logic             issued_q;
	logic             advance;

	logic [15:0]      raw_dx;
	logic [15:0]      raw_dy;
	logic [15:0]      rxm_q;
	logic [15:0]      rym_q;
	logic             negx_q;
	logic             negy_q;
	logic             layer_q;
	logic             lock_q;
	logic             clear_q;
	logic [7:0]       scale_q;
	logic [7:0]       w_q;
	logic [15:0]      m_q;
	logic [15:0]      dxm_q;
	logic [15:0]      dym_q;
	logic [MAG_W-1:0] qxm_q;
	logic [MAG_W-1:0] qym_q;
	logic [MAG_W-1:0] xm_q;
	logic [MAG_W-1:0] ym_q;
	logic [NUM_W-1:0] prod_q;
	logic [MAG_W-1:0] mul_a;
	logic [15:0]      mul_b;
	logic [46:0]      prod_full;
	logic [NUM_W-1:0] num_x;
	logic [NUM_W-1:0] num_y;
	logic [7:0]       scale_sel;

	logic [15:0]      sum_dx_q;
	logic [15:0]      sum_dy_q;
	logic [15:0]      sum_sx_q;
	logic [15:0]      sum_sy_q;
	logic             m_tvalid_q;
	logic [63:0]      m_tdata_q;
	logic             out_free;
	logic             fin_fire;
	logic             accept;
	logic             y_wins;
	logic [MAG_W-1:0] kx;
	logic [MAG_W-1:0] ky;
	logic [16:0]      cx;
	logic [16:0]      cy;
	logic [16:0]      cy_neg;
	logic [15:0]      new_dx;
	logic [15:0]      new_dy;
	logic [15:0]      new_sx;
	logic [15:0]      new_sy;

	tma_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	tma_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_dividend),
		.divisor  (div_divisor),
		.nbits    (div_nbits),
		.busy     (div_busy),
		.done     (div_done),
		.quotient (div_quo)
	);

	assign raw_dx = s_tdata[15:0];
	assign raw_dy = s_tdata[31:16];
	assign s_tready = (state_q == ST_IDLE);
	assign accept = s_tvalid && s_tready;
	assign out_free = !m_tvalid_q || m_tready;
	assign fin_fire = (state_q == ST_FIN) && out_free;
	assign scale_sel = s_tuser[1] ? cfg.scroll_scale : cfg.pointer_scale;

	assign num_x = NUM_W'(dxm_q) + prod_q;
	assign num_y = NUM_W'(dym_q) + prod_q;

	always_comb begin
		in_div = 1'b1;
		skip_div = 1'b0;
		div_dividend = '0;
		div_divisor = {8'd0, scale_q};
		div_nbits = NB_SHORT;
		unique case (state_q)
			ST_DIV_M:  div_dividend = {cfg.sensor_cpi, 24'd0};
			ST_DIV_DX: div_dividend = {rxm_q, 24'd0};
			ST_DIV_DY: div_dividend = {rym_q, 24'd0};
			ST_DIV_QX, ST_DIV_QY: begin
				div_dividend = {prod_q[MAG_W-1:0], 9'd0};
				div_divisor = m_q;
				div_nbits = NB_QUAD;
				skip_div = (m_q == 16'd0);
			end
			ST_DIV_NX: begin
				div_dividend = {num_x, 1'b0};
				div_divisor = {7'd0, 9'(w_q) + 9'd1};
				div_nbits = NB_BLEND;
			end
			ST_DIV_NY: begin
				div_dividend = {num_y, 1'b0};
				div_divisor = {7'd0, 9'(w_q) + 9'd1};
				div_nbits = NB_BLEND;
			end
			default: in_div = 1'b0;
		endcase
	end

	assign div_start = in_div && !skip_div && !issued_q && !div_busy;

	always_comb begin
		mul_a = MAG_W'(dxm_q);
		mul_b = dxm_q;
		unique case (state_q)
			ST_SQ_Y: begin
				mul_a = MAG_W'(dym_q);
				mul_b = dym_q;
			end
			ST_MUL_X: begin
				mul_a = qxm_q;
				mul_b = {8'd0, w_q};
			end
			ST_MUL_Y: begin
				mul_a = qym_q;
				mul_b = {8'd0, w_q};
			end
			default: ;
		endcase
	end

	assign prod_full = mul_a * mul_b;

	always_comb begin
		advance = 1'b0;
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (accept)
					state_d = (s_tuser[0] && !s_tuser[3]) ? ST_DIV_M : ST_FIN;
			end
			ST_DIV_M:  if (div_done) state_d = ST_DIV_DX;
			ST_DIV_DX: if (div_done) state_d = ST_DIV_DY;
			ST_DIV_DY: if (div_done) state_d = ST_SQ_X;
			ST_SQ_X:   state_d = ST_DIV_QX;
			ST_DIV_QX: if (div_done || skip_div) state_d = ST_SQ_Y;
			ST_SQ_Y:   state_d = ST_DIV_QY;
			ST_DIV_QY: if (div_done || skip_div) state_d = ST_MUL_X;
			ST_MUL_X:  state_d = ST_DIV_NX;
			ST_DIV_NX: if (div_done) state_d = ST_MUL_Y;
			ST_MUL_Y:  state_d = ST_DIV_NY;
			ST_DIV_NY: if (div_done) state_d = ST_FIN;
			ST_FIN:    if (out_free) state_d = ST_IDLE;
			default:   state_d = ST_IDLE;
		endcase
		advance = in_div && (div_done || skip_div);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			issued_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (advance)
				issued_q <= 1'b0;
			else if (div_start)
				issued_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			rxm_q <= raw_dx[15] ? (~raw_dx + 16'd1) : raw_dx;
			rym_q <= raw_dy[15] ? (~raw_dy + 16'd1) : raw_dy;
			negx_q <= raw_dx[15];
			negy_q <= raw_dy[15];
			layer_q <= s_tuser[1];
			lock_q <= s_tuser[2];
			clear_q <= s_tuser[3];
			scale_q <= (scale_sel == 8'd0) ? 8'd1 : scale_sel;
			w_q <= s_tuser[1] ? cfg.scroll_quad_weight : cfg.pointer_quad_weight;
			xm_q <= '0;
			ym_q <= '0;
		end
		if (state_q == ST_SQ_X || state_q == ST_SQ_Y || state_q == ST_MUL_X
				|| state_q == ST_MUL_Y)
			prod_q <= prod_full[NUM_W-1:0];
		if (advance) begin
			unique case (state_q)
				ST_DIV_M:  m_q <= div_quo[15:0];
				ST_DIV_DX: dxm_q <= div_quo[15:0];
				ST_DIV_DY: dym_q <= div_quo[15:0];
				ST_DIV_QX: qxm_q <= skip_div ? '0 : div_quo[MAG_W-1:0];
				ST_DIV_QY: qym_q <= skip_div ? '0 : div_quo[MAG_W-1:0];
				ST_DIV_NX: xm_q <= div_quo[MAG_W-1:0];
				ST_DIV_NY: ym_q <= div_quo[MAG_W-1:0];
				default: ;
			endcase
		end
	end

	// lock to dominant axis, cap, route to pointer or scroll; setup mode clears all
	always_comb begin
		y_wins = xm_q < ym_q;
		kx = (lock_q && y_wins) ? '0 : xm_q;
		ky = (lock_q && !y_wins) ? '0 : ym_q;
		cx = cap_signed(negx_q, kx);
		cy = cap_signed(negy_q, ky);
		cy_neg = cap_signed(!negy_q, ky);
		if (layer_q) begin
			new_dx = sum_dx_q;
			new_dy = sum_dy_q;
			new_sx = sat_add(sum_sx_q, cx);
			new_sy = sat_add(sum_sy_q, cy_neg);
		end else begin
			new_dx = sat_add(sum_dx_q, cx);
			new_dy = sat_add(sum_dy_q, cy);
			new_sx = sum_sx_q;
			new_sy = sum_sy_q;
		end
		if (clear_q) begin
			new_dx = 16'd0;
			new_dy = 16'd0;
			new_sx = 16'd0;
			new_sy = 16'd0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_dx_q <= 16'd0;
			sum_dy_q <= 16'd0;
			sum_sx_q <= 16'd0;
			sum_sy_q <= 16'd0;
			m_tvalid_q <= 1'b0;
		end else begin
			if (fin_fire) begin
				sum_dx_q <= new_dx;
				sum_dy_q <= new_dy;
				sum_sx_q <= new_sx;
				sum_sy_q <= new_sy;
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (fin_fire)
			m_tdata_q <= {new_sy, new_sx, new_dy, new_dx};
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata = m_tdata_q;

endmodule

FILE: sv/tma_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tma_checker
// Port-level checks of the trackball motion accelerator, bound to the top.
// ----------------------------------------------------------------------------
module tma_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tvalid,
	input logic        s_tready,
	input logic [3:0]  s_tuser,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [63:0] m_tdata
);

	// hold a stalled result word
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result word changed while stalled");

	// drop ready once a word is taken
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("ready stayed high after accept");

	// keep every accumulator inside +-32767
	a_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata[15:0] != 16'h8000) && (m_tdata[31:16] != 16'h8000)
			&& (m_tdata[47:32] != 16'h8000) && (m_tdata[63:48] != 16'h8000))
		else $error("accumulator out of range");

	// a config-mode word with no stall ahead passes the finish state and yields zeros
	a_clear: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready && s_tuser[3] && !m_tvalid ##1 1'b1 |=> m_tvalid
			&& (m_tdata == 64'd0))
		else $error("config mode did not clear accumulators");

endmodule

bind trackball_motion_accelerator tma_checker u_tma_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.s_tuser  (s_tuser),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);
